@@ design/rle_pkg.sv @@
// Shared types and constants for the byte run-length encoder.
// No dependencies; the classifier, packet writer and top level import this package.
`default_nettype none

package rle_pkg;

    // Literal packet capacity, default run limit and legal run limit range
    localparam int         MAX_LITERAL_DEF = 48;
    localparam logic [7:0] MAX_RUN_RESET   = 8'd128;
    localparam logic [7:0] RUN_MIN         = 8'd3;
    localparam logic [7:0] RUN_MAX         = 8'd128;

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Commands passed from the classifier to the packet writer
    typedef enum logic [1:0] {
        CMD_LIT,    // append value to the literal store
        CMD_FLUSH,  // send literal packet of count bytes
        CMD_RUN,    // send run packet: negated count, value
        CMD_MARK    // end of one input item: tag the last byte
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] count;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

endpackage

`default_nettype wire

@@ design/rle_fifo.sv @@
// Small synchronous FIFO built from registers.
// Generic payload vector; no package dependencies.
`default_nettype none

module rle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ design/rle_front.sv @@
// Classifier: takes input bytes, tracks run and literal counts, and
// issues packet commands. Depends on rle_pkg.
`default_nettype none

module rle_front #(
    parameter int MAX_LITERAL = rle_pkg::MAX_LITERAL_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_block,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_data,
    output logic          o_cmd_push,
    output rle_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full
);
    import rle_pkg::*;

    localparam int CW = $clog2(MAX_LITERAL + 1);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_START = 3'd1;
    localparam logic [2:0] F_CLOSE = 3'd2;
    localparam logic [2:0] F_FINAL = 3'd3;
    localparam logic [2:0] F_MARK  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_lc, n_lc;
    logic [7:0]    r_cc, n_cc;
    logic [7:0]    r_cv, n_cv;
    logic [7:0]    r_b, n_b;
    logic          r_end, n_end;
    logic          r_load, n_load;
    logic [7:0]    r_max;

    logic [7:0]    v_max;
    logic [7:0]    cc_inc;
    logic          lc_nz;
    logic          lc_full;
    logic          lit_tight;
    logic          extend;
    logic          flush_on_ext;
    logic          want;
    t_cmd          cmd;
    logic          stall;

    // Clamp the run limit to its legal range
    always_comb begin
        v_max = r_max;
        if (r_max < RUN_MIN) begin
            v_max = RUN_MIN;
        end else if (r_max > RUN_MAX) begin
            v_max = RUN_MAX;
        end
    end

    assign cc_inc       = r_cc + 8'd1;
    assign lc_nz        = (r_lc != '0);
    assign lc_full      = (r_lc == CW'(MAX_LITERAL));
    assign lit_tight    = ({2'b00, r_lc} + (CW + 2)'(2)) > (CW + 2)'(MAX_LITERAL);
    assign extend       = (r_cc != 8'd0) && (r_b == r_cv) && (r_cc < v_max);
    assign flush_on_ext = ((cc_inc == 8'd2) && lit_tight) || (cc_inc == RUN_MIN);

    always_comb begin
        n_state = r_state;
        n_lc    = r_lc;
        n_cc    = r_cc;
        n_cv    = r_cv;
        n_b     = r_b;
        n_end   = r_end;
        n_load  = r_load;
        want    = 1'b0;
        cmd     = '{kind: CMD_MARK, count: 8'(r_lc), value: r_cv};

        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_b     = i_in_byte;
                    n_end   = i_end_of_block;
                    n_state = F_START;
                end
            end
            F_START: begin
                if (extend) begin
                    n_cc   = cc_inc;
                    n_load = 1'b0;
                    if (flush_on_ext && lc_nz) begin
                        want     = 1'b1;
                        cmd.kind = CMD_FLUSH;
                        n_lc     = '0;
                    end
                    n_state = r_end ? F_CLOSE : F_MARK;
                end else begin
                    n_load  = 1'b1;
                    n_state = F_CLOSE;
                end
            end
            F_CLOSE: begin
                if (lc_full) begin
                    // literal packet reached capacity
                    want     = 1'b1;
                    cmd.kind = CMD_FLUSH;
                    n_lc     = '0;
                end else if (r_cc >= RUN_MIN) begin
                    want = 1'b1;
                    if (lc_nz) begin
                        cmd.kind = CMD_FLUSH;
                        n_lc     = '0;
                    end else begin
                        cmd.kind  = CMD_RUN;
                        cmd.count = r_cc;
                        n_cc      = 8'd0;
                    end
                end else if (r_cc != 8'd0) begin
                    want     = 1'b1;
                    cmd.kind = CMD_LIT;
                    n_lc     = r_lc + 1'b1;
                    n_cc     = r_cc - 8'd1;
                end else if (r_load) begin
                    n_cv    = r_b;
                    n_cc    = 8'd1;
                    n_load  = 1'b0;
                    n_state = r_end ? F_CLOSE : F_MARK;
                end else begin
                    n_state = F_FINAL;
                end
            end
            F_FINAL: begin
                if (lc_nz) begin
                    want     = 1'b1;
                    cmd.kind = CMD_FLUSH;
                    n_lc     = '0;
                end
                n_state = F_MARK;
            end
            F_MARK: begin
                want     = 1'b1;
                cmd.kind = CMD_MARK;
                n_state  = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign stall      = want && i_cmd_full;
    assign o_cmd_push = want && !i_cmd_full;
    assign o_cmd      = cmd;
    assign o_full     = (r_state != F_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_lc    <= '0;
            r_cc    <= 8'd0;
            r_cv    <= 8'd0;
            r_load  <= 1'b0;
        end else if (!stall) begin
            r_state <= n_state;
            r_lc    <= n_lc;
            r_cc    <= n_cc;
            r_cv    <= n_cv;
            r_load  <= n_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_b   <= n_b;
            r_end <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RUN_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

@@ design/rle_back.sv @@
// Packet writer: executes commands, owns the literal store, and
// holds back one byte so the last byte of an item can be tagged. Uses rle_pkg.
`default_nettype none

module rle_back #(
    parameter int MAX_LITERAL = rle_pkg::MAX_LITERAL_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rle_pkg::t_cmd  i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    output logic           o_beat_push,
    output rle_pkg::t_beat o_beat,
    input  logic           i_beat_full
);
    import rle_pkg::*;

    localparam int CW = $clog2(MAX_LITERAL + 1);
    localparam int IW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_LIT  = 2'd1;
    localparam logic [1:0] B_RUNV = 2'd2;

    logic [7:0]    r_store [MAX_LITERAL];
    logic [7:0]    r_rd_data;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_wr, n_wr;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_left, n_left;
    logic [7:0]    r_val, n_val;
    logic [7:0]    r_hold, n_hold;
    logic          r_hold_vld, n_hold_vld;

    logic          can_put;
    logic          pop;
    logic          produce;
    logic [7:0]    new_byte;
    logic          mark_push;
    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] rd_addr;

    assign can_put = !r_hold_vld || !i_beat_full;
    assign pop     = (r_state == B_IDLE) && !i_cmd_empty && can_put;

    always_comb begin
        n_state   = r_state;
        n_wr      = r_wr;
        n_idx     = r_idx;
        n_left    = r_left;
        n_val     = r_val;
        produce   = 1'b0;
        new_byte  = 8'd0;
        mark_push = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        rd_addr   = '0;

        unique case (r_state)
            B_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.kind)
                        CMD_LIT: begin
                            mem_we = 1'b1;
                            n_wr   = r_wr + 1'b1;
                        end
                        CMD_FLUSH: begin
                            produce  = 1'b1;
                            new_byte = i_cmd.count;
                            mem_re   = 1'b1;
                            n_idx    = CW'(1);
                            n_left   = i_cmd.count[CW-1:0];
                            n_wr     = '0;
                            n_state  = B_LIT;
                        end
                        CMD_RUN: begin
                            produce  = 1'b1;
                            new_byte = 8'd0 - i_cmd.count;
                            n_val    = i_cmd.value;
                            n_state  = B_RUNV;
                        end
                        CMD_MARK: begin
                            mark_push = r_hold_vld;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_LIT: begin
                if (can_put) begin
                    produce  = 1'b1;
                    new_byte = r_rd_data;
                    n_left   = r_left - 1'b1;
                    if (r_left > CW'(1)) begin
                        // fetch the next stored literal
                        mem_re  = 1'b1;
                        rd_addr = r_idx[IW-1:0];
                        n_idx   = r_idx + 1'b1;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_RUNV: begin
                if (can_put) begin
                    produce  = 1'b1;
                    new_byte = r_val;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Hold one byte back; release it tagged on the item marker
    always_comb begin
        n_hold      = r_hold;
        n_hold_vld  = r_hold_vld;
        o_beat_push = 1'b0;
        o_beat      = '{data: r_hold, last: 1'b0};
        if (produce) begin
            o_beat_push = r_hold_vld;
            n_hold      = new_byte;
            n_hold_vld  = 1'b1;
        end else if (mark_push) begin
            o_beat_push = 1'b1;
            o_beat.last = 1'b1;
            n_hold_vld  = 1'b0;
        end
    end

    assign o_cmd_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_wr       <= '0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr       <= n_wr;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        r_val  <= n_val;
        r_hold <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_wr[IW-1:0]] <= i_cmd.value;
        end
        if (mem_re) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/rle_byte_encoder.sv @@
// Top level of the byte run-length encoder: classifier, command queue,
// packet writer and output queue. Depends on rle_pkg, rle_front, rle_fifo and rle_back.
//
//  channel   direction  handshake                    payload
//  input     in         push / full                  i_in_byte, i_end_of_block
//  result    out        empty / pop                  o_out_byte, o_last_out
//  config    in         cfg_valid / cfg_ready        i_cfg_max_run_length
//
// Flow: the classifier is a sequencer that issues at most one command per cycle,
// stalling while the command queue is full; an item holds the input side until
// the sequencer has worked through it and returned to idle. The packet writer
// sends at most one byte per cycle while the output queue has room, and the command
// queue lets the classifier run ahead meanwhile.
// Reset: synchronous, active low; the literal store is not cleared.
// Stalls: a full output queue backs up into the command queue, then full.
`default_nettype none

module rle_byte_encoder #(
    parameter int MAX_LITERAL = rle_pkg::MAX_LITERAL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_block,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] i_cfg_max_run_length
);
    import rle_pkg::*;

    t_cmd  cmd_wr;
    t_cmd  cmd_rd;
    logic  cmd_push;
    logic  cmd_full;
    logic  cmd_pop;
    logic  cmd_empty;
    t_beat beat_wr;
    t_beat beat_rd;
    logic  beat_push;
    logic  beat_full;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Classify bytes and issue packet commands
    rle_front #(
        .MAX_LITERAL (MAX_LITERAL)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_in_byte      (i_in_byte),
        .i_end_of_block (i_end_of_block),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_data     (i_cfg_max_run_length),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_wr),
        .i_cmd_full     (cmd_full)
    );

    // Decouple classification from packet writing
    rle_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_wr),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rd),
        .o_empty (cmd_empty)
    );

    // Expand commands into stream bytes
    rle_back #(
        .MAX_LITERAL (MAX_LITERAL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_rd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_beat_push (beat_push),
        .o_beat      (beat_wr),
        .i_beat_full (beat_full)
    );

    // Result beats wait here for the consumer
    rle_fifo #(
        .WIDTH ($bits(t_beat)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (beat_push),
        .i_data  (beat_wr),
        .o_full  (beat_full),
        .i_pop   (pop),
        .o_data  (beat_rd),
        .o_empty (empty)
    );

    assign o_out_byte = beat_rd.data;
    assign o_last_out = beat_rd.last;

endmodule

`default_nettype wire

@@ design/rle_port_chk.sv @@
// Port-level checks for the byte run-length encoder, bound to the top level.
// Depends only on the ports of rle_byte_encoder.
`default_nettype none

module rle_port_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_last_out,
    input logic       cfg_ready
);

    // Reset drops every waiting result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results present after reset");

    // An accepted byte occupies the classifier and holds off further input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("input not held off after accepted beat");

    // Register port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ready)
        else $error("config port not ready");

    // A waiting result beat holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_last_out))
        else $error("result beat changed while waiting");

endmodule

bind rle_byte_encoder rle_port_chk u_port_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_last_out (o_last_out),
    .cfg_ready  (cfg_ready)
);

`default_nettype wire

@@ bench/rle_packet_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the byte run-length encoder: predicts the packet stream from
// accepted input beats and config writes, then checks every output beat.
// Depends on rle_pkg for the run limits and the output beat type.
module rle_packet_checker #(
    parameter int LIT_CAP = rle_pkg::MAX_LITERAL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_block,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_out_byte,
    input  logic       i_last_out,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    import rle_pkg::*;

    t_beat       expected_beats [$];
    logic [7:0]  lit_buf [LIT_CAP];
    int unsigned lit_len;
    int unsigned run_len;
    int unsigned step_beats;
    logic [7:0]  run_byte;
    logic [7:0]  run_limit;
    int          fail_total = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_total++;
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    function automatic void expect_byte(input logic [7:0] b);
        t_beat beat;
        beat.data = b;
        beat.last = 1'b0;
        expected_beats.push_back(beat);
        step_beats++;
    endfunction

    function automatic void send_literals();
        if (lit_len == 0)
            return;
        expect_byte(8'(lit_len));
        for (int i = 0; i < lit_len; i++)
            expect_byte(lit_buf[i]);
        lit_len = 0;
    endfunction

    function automatic void add_literal(input logic [7:0] b);
        if (lit_len < LIT_CAP)
            lit_buf[lit_len] = b;
        lit_len++;
        if (lit_len >= LIT_CAP)
            send_literals();
    endfunction

    function automatic void close_run();
        if (run_len >= 3) begin
            send_literals();
            expect_byte(8'(256 - run_len));
            expect_byte(run_byte);
        end else begin
            repeat (run_len) add_literal(run_byte);
        end
        run_len = 0;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic blk_end);
        int unsigned lim;
        t_beat       tail;
        lim = (run_limit < RUN_MIN) ? RUN_MIN : (run_limit > RUN_MAX) ? RUN_MAX : run_limit;
        step_beats = 0;
        if (run_len > 0 && b == run_byte && run_len < lim) begin
            run_len++;
            // a pair the literal buffer can no longer hold goes out first
            if (run_len == 2 && lit_len + 2 > LIT_CAP)
                send_literals();
            if (run_len == 3)
                send_literals();
        end else begin
            close_run();
            run_byte = b;
            run_len  = 1;
        end
        if (blk_end) begin
            close_run();
            send_literals();
        end
        if (step_beats > 0) begin
            tail = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_beat want;
        if (!i_rst_n) begin
            expected_beats.delete();
            lit_len   = 0;
            run_len   = 0;
            run_byte  = 8'h00;
            run_limit = MAX_RUN_RESET;
        end else begin
            // check before predicting: a beat leaving now came from older input
            if (i_pop && !i_empty) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing outstanding", i_out_byte, 8'h00);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_byte !== want.data)
                        report_mismatch("out_byte", i_out_byte, want.data);
                    if (i_last_out !== want.last)
                        report_mismatch("last_out", 8'(i_last_out), 8'(want.last));
                end
            end
            if (i_push && !i_full)
                encode_byte(i_in_byte, i_end_of_block);
            if (i_cfg_valid && i_cfg_ready)
                run_limit = i_cfg_data;
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_beats.size();
    end

endmodule

@@ bench/rle_byte_encoder_tb.sv @@
`timescale 1ns / 1ps
// Top of the run-length encoder bench: clock, reset, stimulus, stalls and verdict.
// Depends on rle_pkg, rle_byte_encoder and rle_packet_checker.
module rle_byte_encoder_tb;

    import rle_pkg::*;

    // Stop when this many cycles pass with no beat moving on any channel
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to let the encoder settle once every expected beat has arrived
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_QUOTA    = 8;
    localparam int LONG_RUN_LEN   = 129;

    // Run limits for the random phases; out-of-range values clamp to 3 or 128
    localparam logic [7:0] PHASE_LIMITS [10] = '{
        8'd3, 8'd255, 8'd0, 8'd7, 8'd128, 8'd1, 8'd16, 8'd129, 8'd4, 8'd2
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_block = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_out;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] i_cfg_max_run_length = 8'h00;

    int          fail_count;
    int          pending;
    int unsigned items_sent = 0;
    int          idle_cycles = 0;
    int          pop_hold = 0;
    bit          tx_gaps_on = 1'b0;
    bit          rx_stalls_on = 1'b1;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rle_byte_encoder u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_in_byte            (i_in_byte),
        .i_end_of_block       (i_end_of_block),
        .empty                (empty),
        .pop                  (pop),
        .o_out_byte           (o_out_byte),
        .o_last_out           (o_last_out),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .i_cfg_max_run_length (i_cfg_max_run_length)
    );

    rle_packet_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_in_byte      (i_in_byte),
        .i_end_of_block (i_end_of_block),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_out_byte     (o_out_byte),
        .i_last_out     (o_last_out),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (i_cfg_max_run_length),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver side: hold pop low for random stretches, mostly short, now and
    // then long; with stalls off, pop goes high once any pending hold runs out.
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
            pop      <= 1'b0;
            pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: count cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one input beat. Insert a random sender gap first when gaps are on;
    // otherwise keep push high and just advance the payload at the falling edge.
    task automatic send_byte(input logic [7:0] b, input logic blk_end);
        int gap;
        gap = 0;
        if (tx_gaps_on) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = 0;
                18, 19: gap = $urandom_range(8, 40);
                default: gap = $urandom_range(1, 3);
            endcase
        end
        if (gap > 0) begin
            @(negedge i_clk);
            push = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push           = 1'b1;
        i_in_byte      = b;
        i_end_of_block = blk_end;
        // hold the beat until the encoder takes it
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    // Drop push, wait for every predicted beat to come out, then let the
    // classifier finish any trailing work that produces no output.
    task automatic wait_drained();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_run_limit(input logic [7:0] limit);
        wait_drained();
        @(negedge i_clk);
        cfg_valid            = 1'b1;
        i_cfg_max_run_length = limit;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // One random block: runs of up to two bytes past the limit, capped at 20,
    // wide-range literal stretches and two-symbol stretches that keep forming
    // pairs and short runs, which walk the literal buffer through its flush
    // points. A stray end-of-block may cut the block early.
    task automatic send_block(input int unsigned run_cap);
        logic [7:0]  blk [$];
        logic [7:0]  v;
        logic [7:0]  a;
        logic [7:0]  b;
        int unsigned segs;
        int unsigned len;
        int unsigned kind;
        segs = $urandom_range(1, 3);
        repeat (segs) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                v   = 8'($urandom);
                len = $urandom_range(1, run_cap);
                repeat (len) blk.push_back(v);
            end else if (kind < 7) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 52)
                                                  : $urandom_range(1, 6);
                repeat (len) blk.push_back(8'($urandom));
            end else begin
                a   = 8'($urandom);
                b   = 8'($urandom);
                len = $urandom_range(6, 16);
                repeat (len) blk.push_back(($urandom_range(0, 2) == 0) ? b : a);
            end
        end
        foreach (blk[i])
            send_byte(blk[i], (i == blk.size() - 1) || ($urandom_range(0, 49) == 0));
    endtask

    initial begin
        logic [7:0]  limit;
        logic [7:0]  v;
        int unsigned eff;
        int unsigned phase_start;

        // Reset once, then release
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, default limit of 128
        send_byte(8'h00, 1'b1);                 // lone literal, lowest byte
        send_byte(8'hFF, 1'b0);                 // pair stays literal
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);                 // literal flushed ahead of a run
        repeat (3) send_byte(8'hA5, 1'b0);
        send_byte(8'h34, 1'b1);                 // run closed, then tail literal
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);

        // Directed, shortest run limit: full runs split and restart
        tx_gaps_on = 1'b1;
        write_run_limit(RUN_MIN);
        for (int i = 0; i < 7; i++)
            send_byte(8'h5A, i == 6);
        for (int i = 0; i < 3; i++)
            send_byte(8'hC3, i == 2);           // block ends on a run exactly at limit

        // Random phases, one per run limit; first without any idling, then
        // idling on both sides, then idling chosen per phase
        for (int p = 0; p < 10; p++) begin
            limit = PHASE_LIMITS[p];
            write_run_limit(limit);
            tx_gaps_on   = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
            rx_stalls_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
            eff = (limit < RUN_MIN) ? RUN_MIN : (limit > RUN_MAX) ? RUN_MAX : limit;
            phase_start = items_sent;
            if (limit == 8'd255) begin
                // longest legal run, then one more equal byte to overflow it
                v = 8'($urandom);
                for (int i = 0; i < LONG_RUN_LEN; i++)
                    send_byte(v, i == LONG_RUN_LEN - 1);
            end
            while (items_sent - phase_start < PHASE_QUOTA)
                send_block((eff + 2 > 20) ? 20 : eff + 2);
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/rle_pkg.sv
design/rle_fifo.sv
design/rle_front.sv
design/rle_back.sv
design/rle_byte_encoder.sv
design/rle_port_chk.sv
bench/rle_packet_checker.sv
bench/rle_byte_encoder_tb.sv
